// ===== rtl/swd_pkg.sv =====
// shared types, constants and the arctangent table of the steerable wheel drive
package swd_pkg;

  localparam int unsigned RADIUS_LIMIT = 16000;
  localparam int unsigned BRIDGE_MAX   = 4095;
  localparam int unsigned HALF_TURN    = 46080;
  localparam int unsigned RIGHT_ANGLE  = 23040;
  localparam int unsigned ROOT_STEPS   = 16;
  localparam int unsigned DIV_STEPS    = 32;

  // item operation codes
  typedef enum logic {
    OP_GEOMETRY = 1'b0,
    OP_DRIVE    = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ARM_LENGTH     = 3'd0,
    REG_LATERAL_OFFSET = 3'd1,
    REG_MOTOR_SCALE    = 3'd2,
    REG_MAX_DEVIATION  = 3'd3,
    REG_CENTER_ANGLE   = 3'd4,
    REG_MIN_PULSE_US   = 3'd5,
    REG_US_PER_DEGREE  = 3'd6,
    REG_PERIOD_US      = 3'd7
  } reg_idx_t;

  // handshake between sequencer and rotation unit
  typedef struct packed {
    logic        start;
    logic [15:0] x0;
    logic [13:0] y0;
  } rot_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] angle;
  } rot_rsp_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_lut(input logic [3:0] i);
    logic [21:0] v;
    unique case (i)
      4'd0:  v = 22'd2949120;
      4'd1:  v = 22'd1740967;
      4'd2:  v = 22'd919879;
      4'd3:  v = 22'd466945;
      4'd4:  v = 22'd234378;
      4'd5:  v = 22'd117304;
      4'd6:  v = 22'd58666;
      4'd7:  v = 22'd29335;
      4'd8:  v = 22'd14668;
      4'd9:  v = 22'd7334;
      4'd10: v = 22'd3667;
      4'd11: v = 22'd1833;
      4'd12: v = 22'd917;
      4'd13: v = 22'd458;
      4'd14: v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/swd_if.sv =====
// request and result channels of the steerable wheel drive
interface swd_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [23:0] turn_radius;
  logic signed [15:0] speed;
  modport source (output valid, operation, turn_radius, speed, input ready);
  modport sink   (input valid, operation, turn_radius, speed, output ready);
endinterface

interface swd_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] wheel_radius;
  logic signed [15:0] steer_angle;
  logic        [15:0] servo_level;
  logic        [11:0] pwm_forward;
  logic        [11:0] pwm_reverse;
  modport source (output valid, wheel_radius, steer_angle, servo_level, pwm_forward,
                  pwm_reverse, input ready);
  modport sink   (input valid, wheel_radius, steer_angle, servo_level, pwm_forward,
                  pwm_reverse, output ready);
endinterface

// ===== rtl/swd_mul.sv =====
// shared registered 16x16 unsigned multiplier
module swd_mul (
  input  logic        clk,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [31:0] p_r
);

  // product is registered and lands in the cycle after the operands
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== rtl/swd_rot.sv =====
// iterative vectoring rotation unit, one micro-rotation per cycle
module swd_rot import swd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rot_req_t req,
  output rot_rsp_t rsp
);

  logic               busy_r;
  logic [3:0]         cnt_r;
  logic               done_r;
  logic [14:0]        ang_r;
  logic signed [32:0] x_r, y_r;
  logic signed [24:0] z_r;
  logic signed [32:0] dx, dy;
  logic signed [24:0] da;
  logic signed [24:0] z_fin, z_rnd;
  logic [16:0]        a_full;

  // shifted terms of the current step
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign da = $signed({3'b000, atan_lut(cnt_r)});

  // final angle after the last step, rounded to 1/256 degree and clamped to 0..90 degrees
  always_comb begin
    z_fin  = (y_r > 0) ? z_r + da : z_r - da;
    z_rnd  = z_fin + 25'sd128;
    a_full = z_rnd[24:8];
    if (z_fin < 0) a_full = '0;
    else if (a_full > 17'(RIGHT_ANGLE)) a_full = 17'(RIGHT_ANGLE);
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= $signed({3'b000, req.x0, 14'd0});
      y_r <= $signed({5'b00000, req.y0, 14'd0});
      z_r <= '0;
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end
      if (cnt_r == 4'd15) ang_r <= a_full[14:0];
    end
  end

  assign rsp = {done_r, ang_r};

endmodule

// ===== rtl/steerable_wheel_drive_top.sv =====
// top level: sequencer with shared multiplier, root and divider steps
// a drive item takes one multiply; an in-range geometry item runs two 16-step roots,
//   16-step rotation, 32-step division, multiplies; saturation skips roots and rotation,
//   zero wheel radius or arm skips the second root and rotation, zero period the division
// throughput: one request at a time; the next is taken the cycle after the result is taken
// reset: synchronous active low; stored radius, angle and duty clear to zero
module steerable_wheel_drive_top import swd_pkg::*; #(
  parameter int unsigned SERVO_MAX_DUTY = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  swd_in_if.sink      in_ch,
  swd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DRV, S_LL, S_OO, S_ROOT, S_WW, S_ROOT2, S_ROT,
    S_SERVO, S_PULSE, S_DPRE, S_DINIT, S_DIV, S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [13:0]        arm_r;
  logic signed [14:0] offset_r;
  logic [15:0]        mscale_r, center_r, minpulse_r, usdeg_r, period_r;
  logic [14:0]        maxdev_r;

  // stored results
  logic signed [16:0] radius_r;
  logic signed [15:0] angle_r;
  logic [15:0]        duty_r;
  logic [11:0]        pwm_f_r, pwm_b_r;

  // work registers
  logic               neg_r, pass_r;
  logic [15:0]        oabs_r, w_r, pulse_r;
  logic [27:0]        ll_r;
  logic [31:0]        sq_n_r, sq_q_r;
  logic [30:0]        sq_b_r;
  logic [15:0]        rem_r;
  logic [4:0]         cnt_r;

  logic [15:0]        mul_a, mul_b;
  logic [31:0]        mul_p;
  rot_req_t           rot_req;
  rot_rsp_t           rot_rsp;

  logic               acc;
  logic signed [17:0] o_val;
  logic [15:0]        spd_mag;
  logic [31:0]        sq_trial, sq_n_nxt, sq_q_nxt;
  logic signed [17:0] s_val;
  logic [15:0]        s_clip;
  logic [16:0]        pulse_sum;
  logic [16:0]        div_trial;
  logic signed [16:0] ang_s, lim_s;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // input-side helpers
  assign o_val   = 18'(in_ch.turn_radius) - 18'(offset_r);
  assign spd_mag = in_ch.speed[15] ? 16'(-in_ch.speed) : 16'(in_ch.speed);

  // multiplier operand selection
  always_comb begin
    mul_a = 16'(arm_r);
    mul_b = 16'(arm_r);
    unique case (state_r)
      S_IDLE: if (in_ch.operation == OP_DRIVE) begin
        mul_a = spd_mag;
        mul_b = mscale_r;
      end
      S_LL:    begin mul_a = oabs_r; mul_b = oabs_r; end
      S_WW:    begin mul_a = w_r;    mul_b = w_r;    end
      S_SERVO: begin mul_a = s_clip; mul_b = usdeg_r; end
      S_DPRE:  begin mul_a = 16'(SERVO_MAX_DUTY); mul_b = pulse_r; end
      default: ;
    endcase
  end

  swd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  // one root step
  always_comb begin
    sq_trial = sq_q_r + 32'(sq_b_r);
    if (sq_n_r >= sq_trial) begin
      sq_n_nxt = sq_n_r - sq_trial;
      sq_q_nxt = (sq_q_r >> 1) + 32'(sq_b_r);
    end else begin
      sq_n_nxt = sq_n_r;
      sq_q_nxt = sq_q_r >> 1;
    end
  end

  // servo angle, pulse and division step
  always_comb begin
    s_val = 18'($signed({2'b00, center_r})) + 18'(angle_r);
    if (s_val < 0) s_clip = '0;
    else if (s_val > 18'sd46080) s_clip = 16'(HALF_TURN);
    else s_clip = s_val[15:0];
    pulse_sum = 17'(minpulse_r) + 17'(mul_p[31:16]);
    div_trial = {rem_r, sq_n_r[31]};
  end

  // signed and limited steering angle
  always_comb begin
    ang_s = neg_r ? -17'($signed({2'b00, rot_rsp.angle}))
                  : 17'($signed({2'b00, rot_rsp.angle}));
    lim_s = 17'($signed({2'b00, maxdev_r}));
    if (ang_s > lim_s) ang_s = lim_s;
    else if (ang_s < -lim_s) ang_s = -lim_s;
  end

  always_comb begin
    rot_req.start = (state_r == S_ROOT) && pass_r && (cnt_r == 5'(ROOT_STEPS - 1));
    rot_req.x0    = sq_q_nxt[15:0];
    rot_req.y0    = arm_r;
  end

  swd_rot u_rot (.clk(clk), .rst_n(rst_n), .req(rot_req), .rsp(rot_rsp));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_r      <= '0;
      offset_r   <= '0;
      mscale_r   <= 16'd256;
      maxdev_r   <= 15'd11520;
      center_r   <= 16'd23040;
      minpulse_r <= 16'd1000;
      usdeg_r    <= 16'd1422;
      period_r   <= 16'd20000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_ARM_LENGTH:     arm_r      <= cfg_data[13:0];
        REG_LATERAL_OFFSET: offset_r   <= $signed(cfg_data[14:0]);
        REG_MOTOR_SCALE:    mscale_r   <= cfg_data;
        REG_MAX_DEVIATION:  maxdev_r   <= cfg_data[14:0];
        REG_CENTER_ANGLE:   center_r   <= cfg_data;
        REG_MIN_PULSE_US:   minpulse_r <= cfg_data;
        REG_US_PER_DEGREE:  usdeg_r    <= cfg_data;
        REG_PERIOD_US:      period_r   <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      radius_r <= '0;
      angle_r  <= '0;
      duty_r   <= '0;
      pwm_f_r  <= '0;
      pwm_b_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (acc) begin
          pwm_f_r <= '0;
          pwm_b_r <= '0;
          if (in_ch.operation == OP_DRIVE) begin
            state_r <= S_DRV;
            neg_r   <= in_ch.speed[15];
            pass_r  <= (in_ch.speed != '0);
          end else if (in_ch.turn_radius > 24'sd16000 ||
                       in_ch.turn_radius < -24'sd16000) begin
            radius_r <= in_ch.turn_radius[23] ? -17'sd16000 : 17'sd16000;
            angle_r  <= '0;
            state_r  <= S_SERVO;
          end else begin
            neg_r   <= in_ch.turn_radius[23];
            oabs_r  <= o_val[17] ? 16'(-o_val) : 16'(o_val);
            state_r <= S_LL;
          end
        end
        S_DRV: begin
          if (pass_r) begin
            if (neg_r) pwm_b_r <= (mul_p[31:20] != '0) ? 12'(BRIDGE_MAX) : mul_p[19:8];
            else       pwm_f_r <= (mul_p[31:20] != '0) ? 12'(BRIDGE_MAX) : mul_p[19:8];
          end
          state_r <= S_OUT;
        end
        S_LL: begin
          ll_r    <= mul_p[27:0];
          state_r <= S_OO;
        end
        S_OO: begin
          sq_n_r  <= 32'(ll_r) + mul_p;
          sq_q_r  <= '0;
          sq_b_r  <= 31'h4000_0000;
          cnt_r   <= '0;
          pass_r  <= 1'b0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          sq_n_r <= sq_n_nxt;
          sq_q_r <= sq_q_nxt;
          sq_b_r <= sq_b_r >> 2;
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'(ROOT_STEPS - 1)) begin
            if (pass_r) begin
              state_r <= S_ROT;
            end else begin
              w_r      <= sq_q_nxt[15:0];
              radius_r <= $signed({1'b0, sq_q_nxt[15:0]});
              if (sq_q_nxt[15:0] == '0 || arm_r == '0) begin
                angle_r <= '0;
                state_r <= S_SERVO;
              end else begin
                state_r <= S_WW;
              end
            end
          end
        end
        S_WW: state_r <= S_ROOT2;
        S_ROOT2: begin
          sq_n_r  <= mul_p - 32'(ll_r);
          sq_q_r  <= '0;
          sq_b_r  <= 31'h4000_0000;
          cnt_r   <= '0;
          pass_r  <= 1'b1;
          state_r <= S_ROOT;
        end
        S_ROT: if (rot_rsp.done) begin
          angle_r <= ang_s[15:0];
          state_r <= S_SERVO;
        end
        S_SERVO: state_r <= S_PULSE;
        S_PULSE: begin
          pulse_r <= pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
          state_r <= S_DPRE;
        end
        S_DPRE: state_r <= S_DINIT;
        S_DINIT: begin
          if (period_r == '0) begin
            duty_r  <= 16'hFFFF;
            state_r <= S_OUT;
          end else begin
            sq_n_r  <= mul_p;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, quotient bits shift into the numerator
          if (div_trial >= 17'(period_r)) begin
            rem_r  <= 16'(div_trial - 17'(period_r));
            sq_n_r <= {sq_n_r[30:0], 1'b1};
          end else begin
            rem_r  <= div_trial[15:0];
            sq_n_r <= {sq_n_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(DIV_STEPS - 1)) begin
            duty_r  <= (sq_n_r[30:15] != '0) ? 16'hFFFF :
                       {sq_n_r[14:0], (div_trial >= 17'(period_r))};
            state_r <= S_OUT;
          end
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result channel
  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.wheel_radius = radius_r;
  assign out_ch.steer_angle  = angle_r;
  assign out_ch.servo_level  = duty_r;
  assign out_ch.pwm_forward  = pwm_f_r;
  assign out_ch.pwm_reverse  = pwm_b_r;

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r != S_IDLE) else $error("accepted request not started");
  a_one_bridge_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(pwm_f_r != '0 && pwm_b_r != '0)) else $error("both bridge sides driven");
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    angle_r <= 16'sd23040 && angle_r >= -16'sd23040) else $error("angle out of range");
`endif

endmodule
